>>> hdl/ssimbw_pkg.sv
// Shared constants for the RGB box-window SSIM block.
package ssimbw_pkg;

  // Side of the square window.
  localparam int WIN = 7;

  // Width of one packed history word: three reference and three image bytes.
  localparam int PIX_W = 48;

  // Width of the luminance and contrast terms (all fit in 38 bits).
  localparam int NW = 40;

  // Window count and per-channel sum widths.
  localparam int CNT_W = 22;
  localparam int SUM_W = 14;
  localparam int SQ_W = 22;
  localparam int PROD_W = 28;

  // Stabilizing constants scaled by 400: 2401*2601 and 2352*23409.
  localparam int LUM_K = 6245001;
  localparam int CS_K = 55057968;

  // Configuration register indexes.
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Largest frame height.
  localparam int MAX_HEIGHT = 4096;

endpackage

>>> hdl/ssimbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssimbw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ssimbw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ssimbw_div #(
  parameter int AW = 56,
  parameter int DW = 40,
  parameter int QB = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QB-1:0] quotient
);

  localparam int CW = $clog2(QB + 1);

  logic [DW-1:0] rem;
  logic [QB-1:0] low;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          ge;

  // The caller guarantees the quotient fits in QB bits, so the upper part
  // of the dividend is already below the divisor.
  assign trial = {rem, low[QB-1]};
  assign ge = trial >= {1'b0, dsr};

  // Control: count QB steps after a start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(QB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit and subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(dividend >> QB);
      low <= dividend[QB-1:0];
      dsr <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dsr}) : DW'(trial);
      low <= low << 1;
      quotient <= {quotient[QB-2:0], ge};
    end
  end

endmodule

>>> hdl/ssim_rgb_box_window.sv
// Top level: sequencer, window history and shared arithmetic for RGB SSIM.
//
// Pixel pairs (reference and reconstructed RGB888) enter in raster order on
// the in_valid/in_ready channel; frame_start marks pixel (0,0). Frame size
// is written on the cfg channel (index 0 width, index 1 height); the user
// writes it only while idle, and the block itself does not enforce this. For
// every pixel that closes a full 7x7 window the block reads the 49 history
// words, forms the per-channel sums, and computes the window SSIM on one
// shared multiplier and one shared divider of FRACTION_BITS+2 steps.
// The last pixel of a frame adds divisions for the three channel means
// (skipped when no window closed) and one for their average, and then
// one result word appears on out_valid/out_ready. in_ready is high only
// while the sequencer is idle. A held result does not block new pixels;
// only the next frame's result waits until the receiver takes the previous
// one. Reset clears positions, sums and the count and sets the size to
// 320x240; the history memory is not cleared and needs no clearing pass.
module ssim_rgb_box_window #(
  parameter int MAX_COLS = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        frame_start,
  input  logic [7:0]  ref_red,
  input  logic [7:0]  ref_green,
  input  logic [7:0]  ref_blue,
  input  logic [7:0]  img_red,
  input  logic [7:0]  img_green,
  input  logic [7:0]  img_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] ssim_red,
  output logic [17:0] ssim_green,
  output logic [17:0] ssim_blue,
  output logic [17:0] ssim_mean,
  output logic [21:0] window_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int F = FRACTION_BITS;
  localparam int NW = ssimbw_pkg::NW;
  localparam int CW = $clog2(MAX_COLS);
  localparam int DEPTH = ssimbw_pkg::WIN * MAX_COLS;
  localparam int RAW = $clog2(DEPTH);
  localparam int QB = F + 2;
  localparam int DAW = NW + F;
  localparam int MW = (F + 1 > ssimbw_pkg::SUM_W) ? F + 1 : ssimbw_pkg::SUM_W;
  localparam int VW = F + 3;
  localparam int SW = VW + 2;
  localparam int ACC_W = F + 24;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WRITE = 5'd1;
  localparam logic [4:0] S_READ  = 5'd2;
  localparam logic [4:0] S_DRAIN = 5'd3;
  localparam logic [4:0] S_M0    = 5'd4;
  localparam logic [4:0] S_M1    = 5'd5;
  localparam logic [4:0] S_M2    = 5'd6;
  localparam logic [4:0] S_M3    = 5'd7;
  localparam logic [4:0] S_TERMS = 5'd8;
  localparam logic [4:0] S_LGO   = 5'd9;
  localparam logic [4:0] S_LWAIT = 5'd10;
  localparam logic [4:0] S_CGO   = 5'd11;
  localparam logic [4:0] S_CWAIT = 5'd12;
  localparam logic [4:0] S_WMUL  = 5'd13;
  localparam logic [4:0] S_WACC  = 5'd14;
  localparam logic [4:0] S_NEXT  = 5'd15;
  localparam logic [4:0] S_FGO   = 5'd16;
  localparam logic [4:0] S_FWAIT = 5'd17;
  localparam logic [4:0] S_AGO   = 5'd18;
  localparam logic [4:0] S_AWAIT = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  logic [4:0] state;

  // Configuration and frame position.
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [CW-1:0] column_position;
  logic [11:0] row_position;
  logic [2:0] row_slot;

  // Latched pixel.
  logic [ssimbw_pkg::PIX_W-1:0] pix;
  logic [CW-1:0] pcol;
  logic [11:0] prow;
  logic [2:0] pslot;
  logic pend_end;

  // Window read counters.
  logic [2:0] rslot;
  logic [CW-1:0] rcol;
  logic [2:0] cc;
  logic [2:0] rc;
  logic rd_valid;
  logic [ssimbw_pkg::PIX_W-1:0] ram_q;
  logic [RAW-1:0] waddr;
  logic [RAW-1:0] raddr;

  // Per-channel window sums.
  logic [ssimbw_pkg::SUM_W-1:0] sx [3];
  logic [ssimbw_pkg::SUM_W-1:0] sy [3];
  logic [ssimbw_pkg::SQ_W-1:0] sxx [3];
  logic [ssimbw_pkg::SQ_W-1:0] syy [3];
  logic [ssimbw_pkg::SQ_W-1:0] sxy [3];

  // Per-window terms.
  logic [1:0] ch;
  logic [ssimbw_pkg::PROD_W-1:0] p_xy;
  logic [ssimbw_pkg::PROD_W-1:0] q_x;
  logic [ssimbw_pkg::PROD_W-1:0] q_y;
  logic [NW-1:0] ln;
  logic [NW-1:0] ld;
  logic [NW-1:0] cn;
  logic [NW-1:0] cd;
  logic [NW-1:0] ln_hold;
  logic [NW-1:0] ld_hold;
  logic [NW-1:0] cn_hold;
  logic [NW-1:0] cd_hold;
  logic [NW-1:0] cn_mag;
  logic [QB-1:0] lum;
  logic [QB-1:0] cs_mag;
  logic cs_neg;

  // Frame accumulators and final values.
  logic signed [ACC_W-1:0] acc [3];
  logic [ssimbw_pkg::CNT_W-1:0] count;
  logic [1:0] fch;
  logic fneg;
  logic signed [VW-1:0] mres [3];
  logic signed [SW-1:0] msum;
  logic [SW-1:0] msum_mag;
  logic [ACC_W-1:0] acc_mag;
  logic signed [VW-1:0] qsig;

  // Shared multiplier and divider.
  logic [MW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [2*MW-1:0] mul_p;
  logic div_start;
  logic [DAW-1:0] div_a;
  logic [NW-1:0] div_d;
  logic div_done;
  logic [QB-1:0] div_q;

  // Effective frame size and next position.
  logic [12:0] weff;
  logic [12:0] heff;
  logic [CW-1:0] col0;
  logic [11:0] row0;
  logic [2:0] slot0;
  logic [ACC_W-1:0] wz;

  assign in_ready = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  // Clamp the written size into the supported range.
  always_comb begin
    if (frame_width == 11'd0) begin
      weff = 13'd1;
    end else if (13'(frame_width) > 13'(MAX_COLS)) begin
      weff = 13'(MAX_COLS);
    end else begin
      weff = 13'(frame_width);
    end
    if (frame_height == 13'd0) begin
      heff = 13'd1;
    end else if (frame_height > 13'(ssimbw_pkg::MAX_HEIGHT)) begin
      heff = 13'(ssimbw_pkg::MAX_HEIGHT);
    end else begin
      heff = frame_height;
    end
    col0 = frame_start ? '0 : column_position;
    row0 = frame_start ? '0 : row_position;
    slot0 = frame_start ? '0 : row_slot;
  end

  // History memory: seven rows of packed pixels.
  assign waddr = RAW'(pslot) * RAW'(MAX_COLS) + RAW'(pcol);
  assign raddr = RAW'(rslot) * RAW'(MAX_COLS) + RAW'(rcol);

  ssimbw_ram #(
    .WIDTH(ssimbw_pkg::PIX_W),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk(clk),
    .we(state == S_WRITE),
    .waddr(waddr),
    .wdata(pix),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // Window terms; all arithmetic is modulo 2^NW and the true values fit.
  always_comb begin
    ln = NW'(p_xy) * NW'(800) + NW'(ssimbw_pkg::LUM_K);
    ld = (NW'(q_x) + NW'(q_y)) * NW'(400) + NW'(ssimbw_pkg::LUM_K);
    cn = (NW'(sxy[ch]) * NW'(49) - NW'(p_xy)) * NW'(800) + NW'(ssimbw_pkg::CS_K);
    cd = (NW'(sxx[ch]) * NW'(49) - NW'(q_x) + NW'(syy[ch]) * NW'(49) - NW'(q_y))
         * NW'(400) + NW'(ssimbw_pkg::CS_K);
  end

  // Final-stage magnitudes and the signed quotient.
  always_comb begin
    cn_mag = cn_hold[NW-1] ? NW'(-cn_hold) : cn_hold;
  end

  always_comb begin
    acc_mag = acc[fch][ACC_W-1] ? ACC_W'(-acc[fch]) : ACC_W'(acc[fch]);
    msum = SW'(mres[0]) + SW'(mres[1]) + SW'(mres[2]);
    msum_mag = msum[SW-1] ? SW'(-msum) : SW'(msum);
    qsig = fneg ? -$signed(VW'(div_q)) : $signed(VW'(div_q));
    wz = ACC_W'(mul_p >> F);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M0: begin
        mul_a = MW'(sx[ch]);
        mul_b = MW'(sy[ch]);
      end
      S_M1: begin
        mul_a = MW'(sx[ch]);
        mul_b = MW'(sx[ch]);
      end
      S_M2: begin
        mul_a = MW'(sy[ch]);
        mul_b = MW'(sy[ch]);
      end
      S_WMUL: begin
        mul_a = MW'(lum);
        mul_b = MW'(cs_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_d = NW'(1);
    unique case (state)
      S_LGO: begin
        div_start = 1'b1;
        div_a = {ln_hold, {F{1'b0}}};
        div_d = ld_hold;
      end
      S_CGO: begin
        div_start = 1'b1;
        div_a = {cn_mag, {F{1'b0}}};
        div_d = cd_hold;
      end
      S_FGO: begin
        div_start = (count != '0);
        div_a = DAW'(acc_mag);
        div_d = NW'(count);
      end
      S_AGO: begin
        div_start = 1'b1;
        div_a = DAW'(msum_mag);
        div_d = NW'(3);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ssimbw_div #(
    .AW(DAW),
    .DW(NW),
    .QB(QB)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_a),
    .divisor(div_d),
    .done(div_done),
    .quotient(div_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd320;
      frame_height <= 13'd240;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssimbw_pkg::CFG_WIDTH: frame_width <= cfg_data[10:0];
        ssimbw_pkg::CFG_HEIGHT: frame_height <= cfg_data;
        default: frame_width <= frame_width;
      endcase
    end
  end

  // Window sums, accumulated as history words return from the memory.
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= '0;
        sy[i] <= '0;
        sxx[i] <= '0;
        syy[i] <= '0;
        sxy[i] <= '0;
      end
    end else if (rd_valid) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= sx[i] + ssimbw_pkg::SUM_W'(ram_q[8*i +: 8]);
        sy[i] <= sy[i] + ssimbw_pkg::SUM_W'(ram_q[24+8*i +: 8]);
        sxx[i] <= sxx[i] + ssimbw_pkg::SQ_W'(ram_q[8*i +: 8] * ram_q[8*i +: 8]);
        syy[i] <= syy[i] + ssimbw_pkg::SQ_W'(ram_q[24+8*i +: 8] * ram_q[24+8*i +: 8]);
        sxy[i] <= sxy[i] + ssimbw_pkg::SQ_W'(ram_q[8*i +: 8] * ram_q[24+8*i +: 8]);
      end
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        pix <= {img_blue, img_green, img_red, ref_blue, ref_green, ref_red};
        pcol <= col0;
        prow <= row0;
        pslot <= slot0;
      end
      S_M1: p_xy <= ssimbw_pkg::PROD_W'(mul_p);
      S_M2: q_x <= ssimbw_pkg::PROD_W'(mul_p);
      S_M3: q_y <= ssimbw_pkg::PROD_W'(mul_p);
      S_TERMS: begin
        ln_hold <= ln;
        ld_hold <= ld;
        cn_hold <= cn;
        cd_hold <= cd;
      end
      S_LWAIT: lum <= div_q;
      S_CWAIT: begin
        cs_mag <= div_q;
        cs_neg <= cn_hold[NW-1];
      end
      S_FGO: fneg <= acc[fch][ACC_W-1];
      S_FWAIT: begin
        if (div_done) begin
          mres[fch] <= qsig;
        end
      end
      S_AGO: fneg <= msum[SW-1];
      default: pix <= pix;
    endcase
    if (state == S_FGO && count == '0) begin
      mres[fch] <= VW'(1) <<< F;
    end
  end

  // Sequencer, positions, accumulators and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      column_position <= '0;
      row_position <= '0;
      row_slot <= '0;
      pend_end <= 1'b0;
      rd_valid <= 1'b0;
      rslot <= '0;
      rcol <= '0;
      cc <= '0;
      rc <= '0;
      ch <= '0;
      fch <= '0;
      count <= '0;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
      out_valid <= 1'b0;
      ssim_red <= '0;
      ssim_green <= '0;
      ssim_blue <= '0;
      ssim_mean <= '0;
      window_count <= '0;
    end else begin
      rd_valid <= (state == S_READ);
      // A taken word frees the output register unless a new one replaces it.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (frame_start) begin
              count <= '0;
              for (int i = 0; i < 3; i++) begin
                acc[i] <= '0;
              end
            end
            // Advance the raster position for the following pixel.
            if (13'(col0) + 13'd1 < weff) begin
              column_position <= col0 + 1'b1;
              row_position <= row0;
              row_slot <= slot0;
              pend_end <= 1'b0;
            end else begin
              column_position <= '0;
              if (13'(row0) + 13'd1 < heff) begin
                row_position <= row0 + 1'b1;
                row_slot <= (slot0 == 3'(ssimbw_pkg::WIN - 1)) ? '0 : slot0 + 1'b1;
                pend_end <= 1'b0;
              end else begin
                row_position <= '0;
                row_slot <= '0;
                pend_end <= 1'b1;
              end
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          rslot <= pslot;
          rcol <= pcol;
          cc <= '0;
          rc <= '0;
          ch <= '0;
          if (32'(pcol) >= ssimbw_pkg::WIN - 1 && 32'(prow) >= ssimbw_pkg::WIN - 1) begin
            count <= count + 1'b1;
            state <= S_READ;
          end else begin
            state <= S_NEXT;
          end
        end
        S_READ: begin
          // Walk the window row by row, right to left.
          if (cc == 3'(ssimbw_pkg::WIN - 1)) begin
            cc <= '0;
            rcol <= pcol;
            rslot <= (rslot == '0) ? 3'(ssimbw_pkg::WIN - 1) : rslot - 1'b1;
            rc <= rc + 1'b1;
            if (rc == 3'(ssimbw_pkg::WIN - 1)) begin
              state <= S_DRAIN;
            end
          end else begin
            cc <= cc + 1'b1;
            rcol <= rcol - 1'b1;
          end
        end
        S_DRAIN: state <= S_M0;
        S_M0: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_TERMS;
        S_TERMS: state <= S_LGO;
        S_LGO: state <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            state <= S_CGO;
          end
        end
        S_CGO: state <= S_CWAIT;
        S_CWAIT: begin
          if (div_done) begin
            state <= S_WMUL;
          end
        end
        S_WMUL: state <= S_WACC;
        S_WACC: begin
          // Window SSIM truncated toward zero, added to the channel sum.
          acc[ch] <= acc[ch] + $signed(cs_neg ? ACC_W'(-wz) : wz);
          if (ch == 2'd2) begin
            state <= S_NEXT;
          end else begin
            ch <= ch + 1'b1;
            state <= S_M0;
          end
        end
        S_NEXT: begin
          fch <= '0;
          state <= pend_end ? S_FGO : S_IDLE;
        end
        S_FGO: begin
          if (count != '0) begin
            state <= S_FWAIT;
          end else if (fch == 2'd2) begin
            state <= S_AGO;
          end else begin
            fch <= fch + 1'b1;
          end
        end
        S_FWAIT: begin
          if (div_done) begin
            if (fch == 2'd2) begin
              state <= S_AGO;
            end else begin
              fch <= fch + 1'b1;
              state <= S_FGO;
            end
          end
        end
        S_AGO: state <= S_AWAIT;
        S_AWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Hand over the result once the output register is free; the
          // divider holds the average until the next start.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            ssim_red <= 18'(mres[0]);
            ssim_green <= 18'(mres[1]);
            ssim_blue <= 18'(mres[2]);
            ssim_mean <= 18'(qsig);
            window_count <= count;
            count <= '0;
            for (int i = 0; i < 3; i++) begin
              acc[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
